/* rtl/assert_macros.svh */
// Assertion macros for the spatial vector transform RTL.
// Depends on nothing; the including module provides clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SVT_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spatial vector transform: assertion failed");

// Next-cycle implication, checked outside reset.
`define SVT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spatial vector transform: assertion failed");

`endif

/* rtl/svt_pkg.sv */
// Shared widths, types and constants of the spatial vector transform.
// Used by all svt modules and by the top level; depends on nothing.
package svt_pkg;

    localparam int VEC_WIDTH     = 32;
    localparam int COEF_WIDTH    = 18;
    localparam int ROT_FRAC      = 16;
    localparam int OFF_FRAC      = 14;
    localparam int CFG_WIDTH     = 3 * COEF_WIDTH;
    localparam int CFG_IDX_WIDTH = 3;

    // Datapath growth: rotation products, three-term sum, rounded rotation,
    // cross products, their difference, rounded cross term, final sum.
    localparam int PROD_WIDTH  = VEC_WIDTH + COEF_WIDTH;
    localparam int ACC_WIDTH   = PROD_WIDTH + 2;
    localparam int ROT_WIDTH   = ACC_WIDTH - ROT_FRAC;
    localparam int XPROD_WIDTH = COEF_WIDTH + ROT_WIDTH;
    localparam int XACC_WIDTH  = XPROD_WIDTH + 1;
    localparam int CROSS_WIDTH = XACC_WIDTH - OFF_FRAC;
    localparam int SUM_WIDTH   = CROSS_WIDTH + 1;

    typedef logic signed [VEC_WIDTH-1:0]   vec_t;
    typedef logic signed [COEF_WIDTH-1:0]  coef_t;
    typedef logic signed [PROD_WIDTH-1:0]  prod_t;
    typedef logic signed [ACC_WIDTH-1:0]   acc_t;
    typedef logic signed [ROT_WIDTH-1:0]   rot_t;
    typedef logic signed [XPROD_WIDTH-1:0] xprod_t;
    typedef logic signed [XACC_WIDTH-1:0]  xacc_t;
    typedef logic signed [CROSS_WIDTH-1:0] cross_t;
    typedef logic signed [SUM_WIDTH-1:0]   sum_t;
    typedef logic [CFG_WIDTH-1:0]          cfg_word_t;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_ROT_ROW_ZERO,
        CFG_ROT_ROW_ONE,
        CFG_ROT_ROW_TWO,
        CFG_OFFSET
    } cfg_index_t;

    // Load strobes for the two register stages of a lane.
    typedef struct packed {
        logic load_a;
        logic load_b;
    } stage_en_t;

    localparam cfg_word_t ROT_ROW_ZERO_RESET = cfg_word_t'(1) << ROT_FRAC;
    localparam cfg_word_t ROT_ROW_ONE_RESET  = cfg_word_t'(1) << (ROT_FRAC + COEF_WIDTH);
    localparam cfg_word_t ROT_ROW_TWO_RESET  = cfg_word_t'(1) << (ROT_FRAC + 2 * COEF_WIDTH);
    localparam cfg_word_t OFFSET_RESET       = '0;

    localparam acc_t  ROT_HALF   = acc_t'(1) <<< (ROT_FRAC - 1);
    localparam xacc_t CROSS_HALF = xacc_t'(1) <<< (OFF_FRAC - 1);

    localparam sum_t SAT_HI = (sum_t'(1) <<< (VEC_WIDTH - 1)) - sum_t'(1);
    localparam sum_t SAT_LO = -(sum_t'(1) <<< (VEC_WIDTH - 1));

endpackage

/* rtl/svt_rot_lane.sv */
// One rotation lane: a row of R dotted with both halves of the input vector.
// Depends on svt_pkg. Two register stages: products, then rounded sums.
module svt_rot_lane
(
    input  logic                 clk,
    input  svt_pkg::stage_en_t   en,
    input  svt_pkg::cfg_word_t   row,
    input  svt_pkg::vec_t        a [3],
    input  svt_pkg::vec_t        b [3],
    output svt_pkg::rot_t        ra,
    output svt_pkg::rot_t        rb
);

    svt_pkg::coef_t coef [3];
    svt_pkg::prod_t pa_reg [3];
    svt_pkg::prod_t pb_reg [3];
    svt_pkg::acc_t  sum_a;
    svt_pkg::acc_t  sum_b;
    svt_pkg::rot_t  ra_reg;
    svt_pkg::rot_t  rb_reg;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            coef[j] = row[j*svt_pkg::COEF_WIDTH +: svt_pkg::COEF_WIDTH];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.load_a)
        begin
            for (int j = 0; j < 3; j++)
            begin
                pa_reg[j] <= svt_pkg::prod_t'(coef[j]) * svt_pkg::prod_t'(a[j]);
                pb_reg[j] <= svt_pkg::prod_t'(coef[j]) * svt_pkg::prod_t'(b[j]);
            end
        end
    end

    // Exact three-term sum plus one half; the part-select floors.
    assign sum_a = svt_pkg::acc_t'(pa_reg[0]) + svt_pkg::acc_t'(pa_reg[1])
                 + svt_pkg::acc_t'(pa_reg[2]) + svt_pkg::ROT_HALF;
    assign sum_b = svt_pkg::acc_t'(pb_reg[0]) + svt_pkg::acc_t'(pb_reg[1])
                 + svt_pkg::acc_t'(pb_reg[2]) + svt_pkg::ROT_HALF;

    always_ff @(posedge clk)
    begin
        if (en.load_b)
        begin
            ra_reg <= sum_a[svt_pkg::ROT_FRAC +: svt_pkg::ROT_WIDTH];
            rb_reg <= sum_b[svt_pkg::ROT_FRAC +: svt_pkg::ROT_WIDTH];
        end
    end

    assign ra = ra_reg;
    assign rb = rb_reg;

endmodule

/* rtl/svt_cross_lane.sv */
// One cross-product lane: rp*wq - rq*wp, with its 14 fraction bits rounded off.
// Depends on svt_pkg. Carries its lane's rotated halves alongside.
module svt_cross_lane
(
    input  logic                 clk,
    input  svt_pkg::stage_en_t   en,
    input  svt_pkg::coef_t       rp,
    input  svt_pkg::coef_t       rq,
    input  svt_pkg::rot_t        wp,
    input  svt_pkg::rot_t        wq,
    input  svt_pkg::rot_t        ra_in,
    input  svt_pkg::rot_t        rb_in,
    output svt_pkg::cross_t      c,
    output svt_pkg::rot_t        ra_out,
    output svt_pkg::rot_t        rb_out
);

    svt_pkg::xprod_t x1_reg;
    svt_pkg::xprod_t x2_reg;
    svt_pkg::rot_t   ra_a_reg;
    svt_pkg::rot_t   rb_a_reg;
    svt_pkg::xacc_t  diff;
    svt_pkg::cross_t c_reg;
    svt_pkg::rot_t   ra_b_reg;
    svt_pkg::rot_t   rb_b_reg;

    always_ff @(posedge clk)
    begin
        if (en.load_a)
        begin
            x1_reg   <= svt_pkg::xprod_t'(rp) * svt_pkg::xprod_t'(wq);
            x2_reg   <= svt_pkg::xprod_t'(rq) * svt_pkg::xprod_t'(wp);
            ra_a_reg <= ra_in;
            rb_a_reg <= rb_in;
        end
    end

    assign diff = svt_pkg::xacc_t'(x1_reg) - svt_pkg::xacc_t'(x2_reg) + svt_pkg::CROSS_HALF;

    always_ff @(posedge clk)
    begin
        if (en.load_b)
        begin
            c_reg    <= diff[svt_pkg::OFF_FRAC +: svt_pkg::CROSS_WIDTH];
            ra_b_reg <= ra_a_reg;
            rb_b_reg <= rb_a_reg;
        end
    end

    assign c      = c_reg;
    assign ra_out = ra_b_reg;
    assign rb_out = rb_b_reg;

endmodule

/* rtl/svt_merge.sv */
// Merge stage: adds the cross term to the proper half, saturates, flags.
// Depends on svt_pkg. Holds the output register of the block.
module svt_merge
(
    input  logic               clk,
    input  logic               load,
    input  logic               force_mode,
    input  svt_pkg::rot_t      ra [3],
    input  svt_pkg::rot_t      rb [3],
    input  svt_pkg::cross_t    c [3],
    output svt_pkg::vec_t      comp [6],
    output logic               sat
);

    svt_pkg::sum_t res [6];
    svt_pkg::vec_t clip [6];
    logic [5:0]    hit;
    svt_pkg::vec_t comp_reg [6];
    logic          sat_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (force_mode)
            begin
                res[i]     = svt_pkg::sum_t'(ra[i]) + svt_pkg::sum_t'(c[i]);
                res[3 + i] = svt_pkg::sum_t'(rb[i]);
            end
            else
            begin
                res[i]     = svt_pkg::sum_t'(ra[i]);
                res[3 + i] = svt_pkg::sum_t'(c[i]) + svt_pkg::sum_t'(rb[i]);
            end
        end
        for (int k = 0; k < 6; k++)
        begin
            if (res[k] > svt_pkg::SAT_HI)
            begin
                clip[k] = svt_pkg::SAT_HI[svt_pkg::VEC_WIDTH-1:0];
                hit[k]  = 1'b1;
            end
            else if (res[k] < svt_pkg::SAT_LO)
            begin
                clip[k] = svt_pkg::SAT_LO[svt_pkg::VEC_WIDTH-1:0];
                hit[k]  = 1'b1;
            end
            else
            begin
                clip[k] = res[k][svt_pkg::VEC_WIDTH-1:0];
                hit[k]  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            comp_reg <= clip;
            sat_reg  <= |hit;
        end
    end

    assign comp = comp_reg;
    assign sat  = sat_reg;

endmodule

/* rtl/spatial_vector_transform.sv */
// Top level of the spatial (Plucker) 6D vector transform.
// Depends on svt_pkg, svt_rot_lane, svt_cross_lane, svt_merge, assert_macros.svh.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one 6-vector and req_type
//   (motion or force) per beat. Output channel (out_valid / out_stall)
//   returns the transformed vector and the saturated flag, one beat per input.
//   Configuration: cfg_we with cfg_index / cfg_data writes rotation rows 0..2
//   and the offset; indexes beyond the offset register are dropped. Write
//   only while no beat is in flight.
//   Five register stages: rotation products, rounded rotation sums, cross
//   products, rounded cross terms, merged output. Throughput: one beat per
//   cycle while the output is not stalled.
//   Three rotation lanes each take one row of R (six 18x32 multipliers per
//   lane); three cross lanes each take one cross component (two 18x36
//   multipliers); the merge stage adds and saturates.
//   Reset: rotation returns to identity, offset to zero, pipeline empties.
//   Stall: when out_stall holds the output beat, each stage keeps loading
//   while the one ahead has room, so up to five beats queue before in_stall
//   rises.
`include "assert_macros.svh"

module spatial_vector_transform
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_we,
    input  logic [svt_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
    input  logic [svt_pkg::CFG_WIDTH-1:0]       cfg_data,

    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                req_type,
    input  svt_pkg::vec_t                       in_comp_0,
    input  svt_pkg::vec_t                       in_comp_1,
    input  svt_pkg::vec_t                       in_comp_2,
    input  svt_pkg::vec_t                       in_comp_3,
    input  svt_pkg::vec_t                       in_comp_4,
    input  svt_pkg::vec_t                       in_comp_5,

    output logic                                out_valid,
    input  logic                                out_stall,
    output svt_pkg::vec_t                       out_comp_0,
    output svt_pkg::vec_t                       out_comp_1,
    output svt_pkg::vec_t                       out_comp_2,
    output svt_pkg::vec_t                       out_comp_3,
    output svt_pkg::vec_t                       out_comp_4,
    output svt_pkg::vec_t                       out_comp_5,
    output logic                                saturated
);

    // Configuration registers.
    svt_pkg::cfg_word_t rot_row_reg [3];
    svt_pkg::cfg_word_t offset_reg;

    // Pipeline control: stages 1..4 live in the lanes, stage 5 in the merge.
    logic [4:1] stage_valid_reg;
    logic       out_valid_reg;
    logic [5:1] load;
    logic [4:1] force_reg;

    svt_pkg::vec_t    in_a [3];
    svt_pkg::vec_t    in_b [3];
    svt_pkg::coef_t   offset [3];
    svt_pkg::rot_t    ra [3];
    svt_pkg::rot_t    rb [3];
    svt_pkg::rot_t    w_sel [3];
    svt_pkg::cross_t  cross_c [3];
    svt_pkg::rot_t    ra_late [3];
    svt_pkg::rot_t    rb_late [3];
    svt_pkg::vec_t    comp [6];
    svt_pkg::stage_en_t rot_en;
    svt_pkg::stage_en_t cross_en;

    // Write a register; drop writes to unused indexes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_row_reg[0] <= svt_pkg::ROT_ROW_ZERO_RESET;
            rot_row_reg[1] <= svt_pkg::ROT_ROW_ONE_RESET;
            rot_row_reg[2] <= svt_pkg::ROT_ROW_TWO_RESET;
            offset_reg     <= svt_pkg::OFFSET_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                svt_pkg::CFG_ROT_ROW_ZERO: rot_row_reg[0] <= cfg_data;
                svt_pkg::CFG_ROT_ROW_ONE:  rot_row_reg[1] <= cfg_data;
                svt_pkg::CFG_ROT_ROW_TWO:  rot_row_reg[2] <= cfg_data;
                svt_pkg::CFG_OFFSET:       offset_reg     <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // A stage loads when it is empty or the stage ahead loads too.
    always_comb
    begin
        load[5] = !out_valid_reg || !out_stall;
        for (int k = 4; k >= 1; k--)
        begin
            load[k] = !stage_valid_reg[k] || load[k + 1];
        end
    end

    assign in_stall = !load[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (load[1])
            begin
                stage_valid_reg[1] <= in_valid;
            end
            for (int k = 2; k <= 4; k++)
            begin
                if (load[k])
                begin
                    stage_valid_reg[k] <= stage_valid_reg[k - 1];
                end
            end
            if (load[5])
            begin
                out_valid_reg <= stage_valid_reg[4];
            end
        end
    end

    // Advance the motion/force select alongside the data.
    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            force_reg[1] <= req_type;
        end
        for (int k = 2; k <= 4; k++)
        begin
            if (load[k])
            begin
                force_reg[k] <= force_reg[k - 1];
            end
        end
    end

    always_comb
    begin
        in_a[0] = in_comp_0;
        in_a[1] = in_comp_1;
        in_a[2] = in_comp_2;
        in_b[0] = in_comp_3;
        in_b[1] = in_comp_4;
        in_b[2] = in_comp_5;
        for (int i = 0; i < 3; i++)
        begin
            offset[i] = offset_reg[i*svt_pkg::COEF_WIDTH +: svt_pkg::COEF_WIDTH];
            // Motion mode crosses r with R*a, force mode with R*b.
            w_sel[i]  = force_reg[2] ? rb[i] : ra[i];
        end
    end

    assign rot_en.load_a   = load[1];
    assign rot_en.load_b   = load[2];
    assign cross_en.load_a = load[3];
    assign cross_en.load_b = load[4];

    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        localparam int P = (i + 1) % 3;
        localparam int Q = (i + 2) % 3;

        svt_rot_lane u_rot_lane
        (
            .clk (clk),
            .en  (rot_en),
            .row (rot_row_reg[i]),
            .a   (in_a),
            .b   (in_b),
            .ra  (ra[i]),
            .rb  (rb[i])
        );

        svt_cross_lane u_cross_lane
        (
            .clk    (clk),
            .en     (cross_en),
            .rp     (offset[P]),
            .rq     (offset[Q]),
            .wp     (w_sel[P]),
            .wq     (w_sel[Q]),
            .ra_in  (ra[i]),
            .rb_in  (rb[i]),
            .c      (cross_c[i]),
            .ra_out (ra_late[i]),
            .rb_out (rb_late[i])
        );
    end

    svt_merge u_merge
    (
        .clk        (clk),
        .load       (load[5]),
        .force_mode (force_reg[4]),
        .ra         (ra_late),
        .rb         (rb_late),
        .c          (cross_c),
        .comp       (comp),
        .sat        (saturated)
    );

    assign out_valid  = out_valid_reg;
    assign out_comp_0 = comp[0];
    assign out_comp_1 = comp[1];
    assign out_comp_2 = comp[2];
    assign out_comp_3 = comp[3];
    assign out_comp_4 = comp[4];
    assign out_comp_5 = comp[5];

    // An empty first stage always takes a beat.
    `SVT_ASSERT_IMPLIES(a_room_accepts, !stage_valid_reg[1], !in_stall)
    // A full pipeline behind a held output pushes back on the input.
    `SVT_ASSERT_IMPLIES(a_full_stalls, out_valid && out_stall && (&stage_valid_reg), in_stall)
    // An accepted beat enters the first stage.
    `SVT_ASSERT_NEXT(a_accept_enters, in_valid && !in_stall, stage_valid_reg[1])
    // A taken output with nothing behind it leaves the output empty.
    `SVT_ASSERT_NEXT(a_drain_empties, out_valid && !out_stall && !stage_valid_reg[4], !out_valid)

endmodule

/* test/tb_spatial_vector_transform.sv */
// Self-checking testbench for spatial_vector_transform: 6D motion and force transforms.
// Depends on svt_pkg and the RTL top level. Stalls and idles both channels at random,
// and checks every output beat against a fixed-point predictor kept in this file.
`timescale 1ns / 100ps

module tb_spatial_vector_transform;

    import svt_pkg::*;

    localparam int PIPE_LATENCY    = 5;
    localparam int CYCLE_LIMIT     = 300000;
    localparam int CFG_SPARE_FIRST = int'(CFG_OFFSET) + 1;
    localparam int CFG_SPARE_LAST  = (1 << CFG_IDX_WIDTH) - 1;
    localparam int ONE_Q16         = 1 << ROT_FRAC;
    localparam int SEGMENT_BEATS   = 30;

    localparam coef_t COEF_MAX = {1'b0, {(COEF_WIDTH - 1){1'b1}}};
    localparam coef_t COEF_MIN = {1'b1, {(COEF_WIDTH - 1){1'b0}}};
    localparam vec_t  VEC_MAX  = {1'b0, {(VEC_WIDTH - 1){1'b1}}};
    localparam vec_t  VEC_MIN  = {1'b1, {(VEC_WIDTH - 1){1'b0}}};
    localparam vec_t  VEC_ALT0 = {(VEC_WIDTH / 2){2'b01}};
    localparam vec_t  VEC_ALT1 = {(VEC_WIDTH / 2){2'b10}};

    typedef enum logic {
        MODE_MOTION = 1'b0,
        MODE_FORCE  = 1'b1
    } xform_mode_t;

    // How wide random values spread: the whole field, a narrow band, or the edges.
    typedef enum int {
        SPREAD_FULL,
        SPREAD_NARROW,
        SPREAD_EDGE
    } value_spread_t;

    typedef struct packed {
        xform_mode_t   mode;
        vec_t [5:0]    comp;
    } vec_item_t;

    typedef struct packed {
        vec_t [5:0]    comp;
        logic          clipped;
    } vec_result_t;

    // Clock, reset and block ports; everything starts at a known value.
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                       cfg_we    = 1'b0;
    logic [CFG_IDX_WIDTH-1:0]   cfg_index = '0;
    cfg_word_t                  cfg_data  = '0;

    logic   in_valid  = 1'b0;
    logic   in_stall;
    logic   req_type  = 1'b0;
    vec_t   in_comp_0 = '0;
    vec_t   in_comp_1 = '0;
    vec_t   in_comp_2 = '0;
    vec_t   in_comp_3 = '0;
    vec_t   in_comp_4 = '0;
    vec_t   in_comp_5 = '0;

    logic   out_valid;
    logic   out_stall = 1'b0;
    vec_t   out_comp_0;
    vec_t   out_comp_1;
    vec_t   out_comp_2;
    vec_t   out_comp_3;
    vec_t   out_comp_4;
    vec_t   out_comp_5;
    logic   saturated;

    // Predictor copy of the configuration registers, reset values from the package.
    cfg_word_t rotation_rows [3] = '{ROT_ROW_ZERO_RESET, ROT_ROW_ONE_RESET, ROT_ROW_TWO_RESET};
    cfg_word_t offset_word       = OFFSET_RESET;

    vec_item_t   pending_vectors [$];
    vec_result_t expected_transforms [$];
    vec_item_t   driven_beat;

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int beats_queued       = 0;
    int beats_accepted     = 0;
    int mismatches         = 0;
    int cycle_count        = 0;
    logic in_taken         = 1'b0;

    spatial_vector_transform u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .in_comp_0  (in_comp_0),
        .in_comp_1  (in_comp_1),
        .in_comp_2  (in_comp_2),
        .in_comp_3  (in_comp_3),
        .in_comp_4  (in_comp_4),
        .in_comp_5  (in_comp_5),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_comp_0 (out_comp_0),
        .out_comp_1 (out_comp_1),
        .out_comp_2 (out_comp_2),
        .out_comp_3 (out_comp_3),
        .out_comp_4 (out_comp_4),
        .out_comp_5 (out_comp_5),
        .saturated  (saturated)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor. All intermediate terms stay well inside 64 bits: the
    // rotation sums reach about 2^50 and the cross sums about 2^53, so
    // plain longint arithmetic is exact.
    // ------------------------------------------------------------------
    function automatic longint widen(vec_t v);
        return longint'(v);
    endfunction

    // Pull signed entry idx out of a packed three-entry register word.
    function automatic longint coef_entry(cfg_word_t word, int idx);
        coef_t e;
        e = coef_t'(word >> (idx * COEF_WIDTH));
        return longint'(e);
    endfunction

    // Round half up, then drop the fraction bits (arithmetic shift floors).
    function automatic longint round_off(longint acc, int frac);
        return (acc + (longint'(1) <<< (frac - 1))) >>> frac;
    endfunction

    function automatic vec_result_t transform_vector(vec_item_t item);
        longint      top_rot [3];
        longint      bot_rot [3];
        longint      lever [3];
        longint      arm [3];
        longint      twist [3];
        longint      sum_top;
        longint      sum_bot;
        longint      comp;
        int          p;
        int          q;
        vec_result_t res;

        res.clipped = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            sum_top = 0;
            sum_bot = 0;
            for (int j = 0; j < 3; j++)
            begin
                sum_top += coef_entry(rotation_rows[i], j) * widen(item.comp[j]);
                sum_bot += coef_entry(rotation_rows[i], j) * widen(item.comp[3 + j]);
            end
            top_rot[i] = round_off(sum_top, ROT_FRAC);
            bot_rot[i] = round_off(sum_bot, ROT_FRAC);
            lever[i]   = coef_entry(offset_word, i);
        end

        // Motion crosses the offset with R*a, force with R*b.
        for (int i = 0; i < 3; i++)
            arm[i] = (item.mode == MODE_FORCE) ? bot_rot[i] : top_rot[i];

        for (int i = 0; i < 3; i++)
        begin
            p = (i + 1) % 3;
            q = (i + 2) % 3;
            twist[i] = round_off(lever[p] * arm[q] - lever[q] * arm[p], OFF_FRAC);
        end

        for (int i = 0; i < 6; i++)
        begin
            if (item.mode == MODE_FORCE)
                comp = (i < 3) ? top_rot[i] + twist[i] : bot_rot[i - 3];
            else
                comp = (i < 3) ? top_rot[i] : twist[i - 3] + bot_rot[i - 3];
            if (comp > longint'(SAT_HI))
            begin
                comp        = longint'(SAT_HI);
                res.clipped = 1'b1;
            end
            else if (comp < longint'(SAT_LO))
            begin
                comp        = longint'(SAT_LO);
                res.clipped = 1'b1;
            end
            res.comp[i] = vec_t'(comp);
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic coef_t random_entry(value_spread_t spread);
        case (spread)
            SPREAD_NARROW: return coef_t'(int'($urandom_range(2 * ONE_Q16)) - ONE_Q16);
            SPREAD_EDGE:   return $urandom_range(1) ? COEF_MAX : COEF_MIN;
            default:       return coef_t'($urandom);
        endcase
    endfunction

    function automatic cfg_word_t random_word(value_spread_t spread);
        return {random_entry(spread), random_entry(spread), random_entry(spread)};
    endfunction

    function automatic vec_item_t random_vector();
        vec_item_t     it;
        value_spread_t spread;
        logic [31:0]   raw;

        it.mode = $urandom_range(1) ? MODE_FORCE : MODE_MOTION;
        spread  = value_spread_t'($urandom_range(SPREAD_EDGE));
        for (int i = 0; i < 6; i++)
        begin
            raw = $urandom;
            case (spread)
                SPREAD_NARROW: it.comp[i] = vec_t'({{7{raw[24]}}, raw[24:0]});
                SPREAD_EDGE:
                    if ($urandom_range(2) == 0)
                        it.comp[i] = vec_t'(raw);
                    else
                        it.comp[i] = raw[0] ? VEC_MAX : VEC_MIN;
                default:       it.comp[i] = vec_t'(raw);
            endcase
        end
        return it;
    endfunction

    // Even components take one value, odd components the other.
    function automatic vec_item_t fill_item(xform_mode_t mode, vec_t even_val, vec_t odd_val);
        vec_item_t it;
        it.mode = mode;
        for (int i = 0; i < 6; i++)
            it.comp[i] = (i % 2 == 0) ? even_val : odd_val;
        return it;
    endfunction

    // Hand one beat to the driver; push on the rising edge, the driver pops on the falling.
    task automatic queue_beat(vec_item_t it);
        @(posedge clk);
        pending_vectors.push_back(it);
        beats_queued++;
    endtask

    task automatic queue_random(int count);
        repeat (count) queue_beat(random_vector());
    endtask

    // Block until every queued beat went in and every result came out.
    task automatic wait_drained();
        @(negedge clk);
        while (beats_accepted != beats_queued || expected_transforms.size() != 0)
            @(negedge clk);
    endtask

    // Write one register and mirror it in the predictor; spare indexes change nothing.
    task automatic write_register(logic [CFG_IDX_WIDTH-1:0] idx, cfg_word_t data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_ROT_ROW_ZERO: rotation_rows[0] = data;
            CFG_ROT_ROW_ONE:  rotation_rows[1] = data;
            CFG_ROT_ROW_TWO:  rotation_rows[2] = data;
            CFG_OFFSET:       offset_word      = data;
            default:          ;
        endcase
    endtask

    task automatic load_transform(cfg_word_t row0, cfg_word_t row1, cfg_word_t row2,
                                  cfg_word_t offset);
        write_register(CFG_ROT_ROW_ZERO, row0);
        write_register(CFG_ROT_ROW_ONE, row1);
        write_register(CFG_ROT_ROW_TWO, row2);
        write_register(CFG_OFFSET, offset);
    endtask

    // Three config segments per idling mode, each spread once; drain halfway
    // through every segment so the sender sits idle until the pipe is empty.
    task automatic run_random_phase(int send_pct, int recv_pct);
        sender_idle_pct    = send_pct;
        receiver_stall_pct = recv_pct;
        for (int seg = 0; seg < 3; seg++)
        begin
            wait_drained();
            load_transform(random_word(value_spread_t'(seg)), random_word(value_spread_t'(seg)),
                           random_word(value_spread_t'(seg)), random_word(value_spread_t'(seg)));
            queue_random(SEGMENT_BEATS);
            wait_drained();
            queue_random(SEGMENT_BEATS);
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: present a new beat on the falling edge once the previous one
    // was taken, and roll the receiver stall for the next edge.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            out_stall <= 1'b0;
        end
        else
        begin
            // Hold a stalled beat; only replace it after acceptance.
            if (!in_valid || in_taken)
            begin
                if (pending_vectors.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    driven_beat = pending_vectors.pop_front();
                    req_type  <= driven_beat.mode;
                    in_comp_0 <= driven_beat.comp[0];
                    in_comp_1 <= driven_beat.comp[1];
                    in_comp_2 <= driven_beat.comp[2];
                    in_comp_3 <= driven_beat.comp[3];
                    in_comp_4 <= driven_beat.comp[4];
                    in_comp_5 <= driven_beat.comp[5];
                    in_valid  <= 1'b1;
                end
                else
                begin
                    in_valid  <= 1'b0;
                end
            end
            out_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: on the rising edge, check an accepted output beat against the
    // oldest expectation, then predict for an accepted input beat. Latency
    // keeps the two apart, so the order inside this block is safe.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        vec_item_t   seen_in;
        vec_result_t seen_out;
        vec_result_t want;

        if (!rst_n)
        begin
            in_taken <= 1'b0;
        end
        else
        begin
            in_taken <= in_valid && !in_stall;

            if (out_valid && !out_stall)
            begin
                if (expected_transforms.size() == 0)
                begin
                    $error("output beat with no expected transform waiting");
                    mismatches++;
                end
                else
                begin
                    want             = expected_transforms.pop_front();
                    seen_out.comp[0] = out_comp_0;
                    seen_out.comp[1] = out_comp_1;
                    seen_out.comp[2] = out_comp_2;
                    seen_out.comp[3] = out_comp_3;
                    seen_out.comp[4] = out_comp_4;
                    seen_out.comp[5] = out_comp_5;
                    seen_out.clipped = saturated;
                    for (int i = 0; i < 6; i++)
                    begin
                        if (seen_out.comp[i] !== want.comp[i])
                        begin
                            $error("out_comp_%0d: expected %0d, actual %0d",
                                   i, want.comp[i], seen_out.comp[i]);
                            mismatches++;
                        end
                    end
                    if (seen_out.clipped !== want.clipped)
                    begin
                        $error("saturated: expected %0b, actual %0b",
                               want.clipped, seen_out.clipped);
                        mismatches++;
                    end
                end
            end

            if (in_valid && !in_stall)
            begin
                seen_in.mode    = xform_mode_t'(req_type);
                seen_in.comp[0] = in_comp_0;
                seen_in.comp[1] = in_comp_1;
                seen_in.comp[2] = in_comp_2;
                seen_in.comp[3] = in_comp_3;
                seen_in.comp[4] = in_comp_4;
                seen_in.comp[5] = in_comp_5;
                expected_transforms.push_back(transform_vector(seen_in));
                beats_accepted++;
            end
        end
    end

    // Watchdog: end the run if the cycle count runs past the limit.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        sender_idle_pct    = 28;
        receiver_stall_pct = 77;

        // Reset config: identity rotation, zero offset; field extremes and bit patterns.
        queue_beat(fill_item(MODE_MOTION, '0, '0));
        queue_beat(fill_item(MODE_FORCE, '0, '0));
        queue_beat(fill_item(MODE_MOTION, VEC_MAX, VEC_MAX));
        queue_beat(fill_item(MODE_FORCE, VEC_MAX, VEC_MAX));
        queue_beat(fill_item(MODE_MOTION, VEC_MIN, VEC_MIN));
        queue_beat(fill_item(MODE_FORCE, VEC_MIN, VEC_MIN));
        queue_beat(fill_item(MODE_MOTION, VEC_ALT0, VEC_ALT1));
        queue_beat(fill_item(MODE_FORCE, VEC_ALT1, VEC_ALT0));

        // Largest positive rotation and offset: drive the outputs into clipping.
        wait_drained();
        load_transform({3{COEF_MAX}}, {3{COEF_MAX}}, {3{COEF_MAX}}, {3{COEF_MAX}});
        queue_beat(fill_item(MODE_MOTION, VEC_MAX, VEC_MAX));
        queue_beat(fill_item(MODE_FORCE, VEC_MIN, VEC_MIN));
        queue_beat(fill_item(MODE_MOTION, VEC_ALT0, VEC_ALT1));

        // Most negative rotation and offset.
        wait_drained();
        load_transform({3{COEF_MIN}}, {3{COEF_MIN}}, {3{COEF_MIN}}, {3{COEF_MIN}});
        queue_beat(fill_item(MODE_FORCE, VEC_MAX, VEC_MAX));
        queue_beat(fill_item(MODE_MOTION, VEC_MIN, VEC_MIN));
        queue_beat(fill_item(MODE_FORCE, VEC_ALT1, VEC_ALT0));

        // Write past the last register: the transform must stay as it was.
        wait_drained();
        write_register(CFG_IDX_WIDTH'($urandom_range(CFG_SPARE_LAST, CFG_SPARE_FIRST)),
                       random_word(SPREAD_FULL));
        queue_beat(fill_item(MODE_MOTION, VEC_MAX, VEC_MIN));
        queue_beat(fill_item(MODE_FORCE, VEC_MIN, VEC_MAX));

        // Offset alone, rotation left at identity.
        wait_drained();
        load_transform(ROT_ROW_ZERO_RESET, ROT_ROW_ONE_RESET, ROT_ROW_TWO_RESET,
                       random_word(SPREAD_FULL));
        queue_beat(fill_item(MODE_MOTION, vec_t'(32'h0001_2345), vec_t'(32'hFFFE_8001)));
        queue_beat(fill_item(MODE_FORCE, vec_t'(32'hFFFE_8001), vec_t'(32'h0001_2345)));

        // Rotation alone, not orthonormal, zero offset.
        wait_drained();
        load_transform(random_word(SPREAD_NARROW), random_word(SPREAD_NARROW),
                       random_word(SPREAD_NARROW), OFFSET_RESET);
        queue_beat(random_vector());
        queue_beat(random_vector());

        // Random traffic: slow receiver first, then slow sender, then no idling.
        run_random_phase(28, 77);
        run_random_phase(77, 28);
        run_random_phase(0, 0);

        // Drain, then watch for stray beats before reporting the result.
        wait_drained();
        repeat (2 * PIPE_LATENCY) @(negedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
